// ----- rtl/mep_pkg.sv -----
// Shared types, constants and helper functions for the Mandelbrot escape-time pixel core.
`timescale 1ns / 1ps

package mep_pkg;

    // Fixed-point format of every coordinate: signed Q4.FRAC_BITS.
    localparam int FRAC_BITS = 28;
    localparam int MAX_DIM   = 4096;

    localparam int QW     = FRAC_BITS + 4;
    localparam int PROD_W = 2 * QW;
    localparam int SQ_W   = PROD_W - 1 - FRAC_BITS;   // truncated square, never negative
    localparam int XW     = PROD_W - FRAC_BITS;       // floored cross product, signed
    localparam int SAT_W  = FRAC_BITS + 10;           // sums ahead of saturation
    localparam int ESC_W  = SQ_W + 1;                 // |z|^2 for the escape test

    // Field and register widths.
    localparam int COORD_W    = 12;
    localparam int DIM_REG_W  = 13;
    localparam int LIMIT_W    = 16;
    localparam int INT_W      = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;

    // Coordinate divider.
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int NUM_W       = COORD_W + 5;            // 23 * row fits here
    localparam int DEN_W       = $clog2(10 * MAX_DIM + 1);
    localparam int QUO_W       = FRAC_BITS + 5;
    localparam int DIV_STEPS   = NUM_W + FRAC_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Intensity scaling.
    localparam int PRD_W         = LIMIT_W + INT_W;
    localparam int INTENSITY_MAX = 172;
    localparam int SCALE_CNT_W   = $clog2(INT_W);

    // Queue between the mapping front end and the iteration back end.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Register reset values.
    localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = DIM_REG_W'(640);
    localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = DIM_REG_W'(480);
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET  = LIMIT_W'(256);

    // Fixed-point constants.
    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW - 1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW - 1){1'b0}}};
    localparam logic signed [SAT_W-1:0] SAT_HI = {{(SAT_W - QW + 1){1'b0}}, {(QW - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_LO = {{(SAT_W - QW + 1){1'b1}}, {(QW - 1){1'b0}}};
    localparam logic signed [SAT_W-1:0] TWO_HALF = SAT_W'(5) << (FRAC_BITS - 1);
    localparam logic signed [SAT_W-1:0] C_115 = (SAT_W'(23) << FRAC_BITS) / SAT_W'(20);
    localparam logic [ESC_W-1:0] ESC_FOUR = ESC_W'(4) << FRAC_BITS;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH  = 0,
        REG_FRAME_HEIGHT = 1,
        REG_ITER_LIMIT   = 2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } fr_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ITER,
        BK_MUL,
        BK_SCALE
    } bk_state_t;

    typedef struct packed {
        logic signed [QW-1:0] cr;
        logic signed [QW-1:0] ci;
    } cpoint_t;

    typedef struct packed {
        logic             valid;
        logic             ovf;
        logic [QUO_W-1:0] quot;
    } div_res_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // A zero dimension counts as one; anything above MAX_DIM counts as MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // Clip a wide signed value into the Q4 range.
    function automatic logic signed [QW-1:0] sat_q(input logic signed [SAT_W-1:0] v);
        logic signed [QW-1:0] r;
        if (v > SAT_HI)
        begin
            r = Q_MAX;
        end
        else if (v < SAT_LO)
        begin
            r = Q_MIN;
        end
        else
        begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/mep_div.sv -----
// Bit-serial restoring divider that forms floor(numer * 2^FRAC_BITS / denom).
`timescale 1ns / 1ps

module mep_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mep_pkg::NUM_W-1:0]   numer,
    input  logic [mep_pkg::DEN_W-1:0]   denom,
    output mep_pkg::div_res_t           res
);
    import mep_pkg::*;

    logic                 run_reg;
    logic                 valid_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0]     dvd_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic                 ovf_reg;

    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_diff;
    logic                 ge;

    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[NUM_W-1]};
        rem_diff = rem_sh - {1'b0, den_reg};
        ge       = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    run_reg   <= 1'b0;
                    valid_reg <= 1'b1;
                end
            end
        end
    end

    // The quotient register keeps the low bits; a one pushed out of the top marks overflow.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[NUM_W-2:0], 1'b0};
            rem_reg <= ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            ovf_reg <= ovf_reg | quo_reg[QUO_W-1];
        end
    end

    always_comb
    begin
        res.valid = valid_reg;
        res.ovf   = ovf_reg;
        res.quot  = quo_reg;
    end

endmodule

// ----- rtl/mep_front.sv -----
// Front end: accepts a pixel item and maps it to the complex point c.
`timescale 1ns / 1ps

module mep_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mep_pkg::COORD_W-1:0]     column,
    input  logic [mep_pkg::COORD_W-1:0]     row,
    input  logic [mep_pkg::DIM_REG_W-1:0]   frame_width,
    input  logic [mep_pkg::DIM_REG_W-1:0]   frame_height,
    input  mep_pkg::q_stat_t                q_stat,
    output logic                            busy,
    output logic                            push,
    output mep_pkg::cpoint_t                point
);
    import mep_pkg::*;

    fr_state_t state_reg;
    fr_state_t state_next;

    logic             div_start;
    logic [NUM_W-1:0] n_re;
    logic [NUM_W-1:0] n_im;
    logic [DEN_W-1:0] d_re;
    logic [DEN_W-1:0] d_im;
    div_res_t         res_re;
    div_res_t         res_im;

    logic signed [SAT_W-1:0] cr_wide;
    logic signed [SAT_W-1:0] ci_wide;

    // Real part: 3*column / width.  Imaginary part: 23*row / (10*height).
    always_comb
    begin
        n_re = NUM_W'(column) + NUM_W'({column, 1'b0});
        n_im = NUM_W'(row) * NUM_W'(23);
        d_re = DEN_W'(clamp_dim(frame_width));
        d_im = DEN_W'(clamp_dim(frame_height)) * DEN_W'(10);
    end

    mep_div u_div_re (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (n_re),
        .denom (d_re),
        .res   (res_re)
    );

    mep_div u_div_im (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (n_im),
        .denom (d_im),
        .res   (res_im)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FR_IDLE:
            begin
                if (start)
                begin
                    state_next = FR_DIV;
                end
            end
            FR_DIV:
            begin
                if (res_re.valid && res_im.valid)
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (!q_stat.full)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != FR_IDLE);
        div_start = (state_reg == FR_IDLE) && start;
        push      = (state_reg == FR_PUSH) && !q_stat.full;
    end

    // The quotients hold after the divide, so c is formed straight from them.
    // An integer part past the quotient register saturates in any case.
    always_comb
    begin
        cr_wide  = SAT_W'(res_re.quot) - TWO_HALF;
        ci_wide  = SAT_W'(res_im.quot) - C_115;
        point.cr = res_re.ovf ? Q_MAX : sat_q(cr_wide);
        point.ci = res_im.ovf ? Q_MAX : sat_q(ci_wide);
    end

endmodule

// ----- rtl/mep_queue.sv -----
// Two-entry queue that carries mapped points from the front end to the back end.
`timescale 1ns / 1ps

module mep_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mep_pkg::cpoint_t  wr_data,
    input  logic              pop,
    output mep_pkg::cpoint_t  rd_data,
    output mep_pkg::q_stat_t  stat
);
    import mep_pkg::*;

    cpoint_t           mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    // The depth is a power of two, so the pointers wrap on their own.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_comb
    begin
        rd_data    = mem[rd_ptr_reg];
        stat.empty = (cnt_reg == '0);
        stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    end

endmodule

// ----- rtl/mep_back.sv -----
// Back end: runs the escape-time iteration for one point and scales the count.
`timescale 1ns / 1ps

module mep_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mep_pkg::LIMIT_W-1:0]   iteration_limit,
    input  mep_pkg::q_stat_t              q_stat,
    input  mep_pkg::cpoint_t              point,
    output logic                          pop,
    output logic                          done,
    output logic [mep_pkg::INT_W-1:0]     intensity,
    output logic [mep_pkg::LIMIT_W-1:0]   iterations
);
    import mep_pkg::*;

    bk_state_t state_reg;
    bk_state_t state_next;

    logic signed [QW-1:0]   cr_reg;
    logic signed [QW-1:0]   ci_reg;
    logic signed [QW-1:0]   zr_reg;
    logic signed [QW-1:0]   zi_reg;
    logic [LIMIT_W-1:0]     iter_reg;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [PRD_W-1:0]       prod_reg;
    logic [PRD_W-1:0]       dvs_reg;
    logic [INT_W-1:0]       quo_reg;
    logic [SCALE_CNT_W-1:0] step_reg;
    logic                   done_reg;
    logic [INT_W-1:0]       intensity_reg;
    logic [LIMIT_W-1:0]     iterations_reg;

    logic signed [PROD_W-1:0] p_rr;
    logic signed [PROD_W-1:0] p_ii;
    logic signed [PROD_W-1:0] p_ri;
    logic [SQ_W-1:0]          rsq;
    logic [SQ_W-1:0]          isq;
    logic signed [XW-1:0]     cross_fl;
    logic                     cross_up;
    logic [ESC_W-1:0]         mag_sq;
    logic                     esc;
    logic                     stop;
    logic signed [SAT_W-1:0]  zr_wide;
    logic signed [SAT_W-1:0]  zi_wide;
    logic                     scale_ge;
    logic [INT_W-1:0]         quo_final;

    logic iterate;
    logic do_mul;
    logic do_scale;
    logic last_step;

    // One iteration per cycle.  Squares are never negative, so dropping the
    // fraction already truncates toward zero; the cross product needs a
    // one-up correction when it is negative with fraction bits set.
    always_comb
    begin
        p_rr     = PROD_W'(zr_reg) * PROD_W'(zr_reg);
        p_ii     = PROD_W'(zi_reg) * PROD_W'(zi_reg);
        p_ri     = PROD_W'(zr_reg) * PROD_W'(zi_reg);
        rsq      = p_rr[PROD_W-2:FRAC_BITS];
        isq      = p_ii[PROD_W-2:FRAC_BITS];
        cross_fl = p_ri[PROD_W-1:FRAC_BITS];
        cross_up = p_ri[PROD_W-1] && (p_ri[FRAC_BITS-1:0] != '0);
        mag_sq   = ESC_W'(rsq) + ESC_W'(isq);
        esc      = (mag_sq >= ESC_FOUR);
        stop     = (iter_reg == limit_reg) || esc;
        zi_wide  = (SAT_W'(cross_fl) <<< 1) + SAT_W'(ci_reg)
                 + {{(SAT_W - 2){1'b0}}, cross_up, 1'b0};
        zr_wide  = SAT_W'(rsq) - SAT_W'(isq) + SAT_W'(cr_reg);
        scale_ge  = (prod_reg >= dvs_reg);
        quo_final = {quo_reg[INT_W-2:0], scale_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= last_step;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = BK_ITER;
                end
            end
            BK_ITER:
            begin
                if (stop)
                begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                state_next = BK_SCALE;
            end
            BK_SCALE:
            begin
                if (step_reg == SCALE_CNT_W'(INT_W - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = (state_reg == BK_IDLE) && !q_stat.empty;
        iterate   = (state_reg == BK_ITER) && !stop;
        do_mul    = (state_reg == BK_MUL);
        do_scale  = (state_reg == BK_SCALE);
        last_step = do_scale && (step_reg == SCALE_CNT_W'(INT_W - 1));
    end

    // The intensity is 172*count/limit; the quotient stays below 256 because
    // the count never passes the limit, so eight restoring steps suffice.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cr_reg    <= point.cr;
            ci_reg    <= point.ci;
            zr_reg    <= '0;
            zi_reg    <= '0;
            iter_reg  <= '0;
            limit_reg <= iteration_limit;
        end
        if (iterate)
        begin
            zr_reg   <= sat_q(zr_wide);
            zi_reg   <= sat_q(zi_wide);
            iter_reg <= iter_reg + LIMIT_W'(1);
        end
        if (do_mul)
        begin
            prod_reg <= PRD_W'(iter_reg) * PRD_W'(INTENSITY_MAX);
            dvs_reg  <= PRD_W'(limit_reg) << (INT_W - 1);
            step_reg <= '0;
        end
        if (do_scale)
        begin
            if (scale_ge)
            begin
                prod_reg <= prod_reg - dvs_reg;
            end
            dvs_reg  <= dvs_reg >> 1;
            quo_reg  <= quo_final;
            step_reg <= step_reg + SCALE_CNT_W'(1);
        end
        if (last_step)
        begin
            intensity_reg  <= (limit_reg == '0) ? '0 : quo_final;
            iterations_reg <= iter_reg;
        end
    end

    always_comb
    begin
        done       = done_reg;
        intensity  = intensity_reg;
        iterations = iterations_reg;
    end

endmodule

// ----- rtl/mandelbrot_escape_pixel_core.sv -----
// Top level of the Mandelbrot escape-time pixel core: registers, front end, queue, back end.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// --------  ---------  -----------------------------  ------------------------------
// pixel     in         start & !busy at a clock edge  column[11:0], row[11:0]
// result    out        done, high for one cycle       intensity[7:0], iterations[15:0]
// config    in         cfg_we at a clock edge         cfg_addr[1:0], cfg_data[15:0]
//
// An item passes the front end in order: 45 steps of the two parallel dividers that
// form c, a look at the quotients, and a push of c into the queue.  The back end
// loads the point, makes iterations + 1 escape checks, forms the 172*count product
// and runs eight divide steps.  The front end takes the next item once it has pushed
// the last one, while the back end may still iterate.  Reset restores 640 x 480 with
// a limit of 256 and empties the queue; busy covers dividing and waiting on a full
// queue.

module mandelbrot_escape_pixel_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [mep_pkg::COORD_W-1:0]      column,
    input  logic [mep_pkg::COORD_W-1:0]      row,
    output logic                             busy,
    output logic                             done,
    output logic [mep_pkg::INT_W-1:0]        intensity,
    output logic [mep_pkg::LIMIT_W-1:0]      iterations,
    input  logic                             cfg_we,
    input  logic [mep_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [mep_pkg::CFG_W-1:0]        cfg_data
);
    import mep_pkg::*;

    logic [DIM_REG_W-1:0] frame_width_reg;
    logic [DIM_REG_W-1:0] frame_height_reg;
    logic [LIMIT_W-1:0]   iteration_limit_reg;

    logic    push;
    logic    pop;
    cpoint_t point_in;
    cpoint_t point_out;
    q_stat_t q_stat;

    // Configuration registers.  They must be written only while the core is idle
    // (the block itself does not enforce this), so the front end and back end may
    // read them without extra staging.  A write to an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg     <= WIDTH_RESET;
            frame_height_reg    <= HEIGHT_RESET;
            iteration_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= cfg_data[DIM_REG_W-1:0];
                end
                REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= cfg_data[DIM_REG_W-1:0];
                end
                REG_ITER_LIMIT:
                begin
                    iteration_limit_reg <= cfg_data[LIMIT_W-1:0];
                end
                default:
                begin
                    iteration_limit_reg <= iteration_limit_reg;
                end
            endcase
        end
    end

    // The front end maps the pixel to c and pushes it once the queue has room.
    mep_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .column       (column),
        .row          (row),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_stat       (q_stat),
        .busy         (busy),
        .push         (push),
        .point        (point_in)
    );

    // The queue lets the front end map the next item while the back end iterates.
    mep_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (point_in),
        .pop     (pop),
        .rd_data (point_out),
        .stat    (q_stat)
    );

    // The back end iterates z = z*z + c and presents the result for one cycle.
    mep_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .iteration_limit (iteration_limit_reg),
        .q_stat          (q_stat),
        .point           (point_out),
        .pop             (pop),
        .done            (done),
        .intensity       (intensity),
        .iterations      (iterations)
    );

endmodule

// ----- rtl/mep_checker.sv -----
// Port-level checker for the Mandelbrot escape-time pixel core and its bind.
`timescale 1ns / 1ps

module mep_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [mep_pkg::INT_W-1:0]     intensity,
    input logic [mep_pkg::LIMIT_W-1:0]   iterations
);
    import mep_pkg::*;

    a_accept_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepting an item");

    a_busy_rises_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an accepted item");

    a_done_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results arrived in back-to-back cycles");

    a_intensity_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (intensity <= INT_W'(INTENSITY_MAX)))
        else $error("intensity above its maximum");

    a_zero_count_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (iterations == '0)) |-> (intensity == '0))
        else $error("nonzero intensity for a zero iteration count");

endmodule

bind mandelbrot_escape_pixel_core mep_checker u_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench for the Mandelbrot escape-time pixel core.
`timescale 1ns / 1ps

module tb_top;

    // Fixed-point constants of the pixel predictor, all in signed Q4.FB held in 64 bits.
    localparam int     FB          = mep_pkg::FRAC_BITS;
    localparam longint Q_HI        = (longint'(8) << FB) - 1;
    localparam longint Q_LO        = -(longint'(8) << FB);
    localparam longint ESC_BOUND   = longint'(4) << FB;
    localparam longint C_RE_OFFSET = longint'(5) << (FB - 1);

    // Run control.  The cycle limit allows for every random item running up to a
    // limit of 1024 iterations, plus the directed items at the 65535 limit.
    localparam longint CYCLE_LIMIT  = 64'd6000000;
    localparam int     RANDOM_ITEMS = 1700;
    localparam int     DRAIN_CYCLES = 60;
    localparam int     N_DIRECTED   = 23;

    typedef struct packed {
        logic [mep_pkg::INT_W-1:0]   intensity;
        logic [mep_pkg::LIMIT_W-1:0] iterations;
    } pixel_result_t;

    // One row of the directed table.  When load is set, the three registers are
    // reprogrammed (with the core idle) before the item is sent.  When typed is set,
    // the expected result is given in the row instead of being computed.
    typedef struct packed {
        logic                          load;
        logic [mep_pkg::CFG_W-1:0]     width_val;
        logic [mep_pkg::CFG_W-1:0]     height_val;
        logic [mep_pkg::CFG_W-1:0]     limit_val;
        logic [mep_pkg::COORD_W-1:0]   col;
        logic [mep_pkg::COORD_W-1:0]   rw;
        logic                          typed;
        logic [mep_pkg::INT_W-1:0]     exp_intensity;
        logic [mep_pkg::LIMIT_W-1:0]   exp_iterations;
    } pixel_case_t;

    // Columns: load, width, height, limit, column, row, typed, intensity, iterations.
    localparam pixel_case_t DIRECTED_CASES [N_DIRECTED] = '{
        // Reset frame 640 x 480, limit 256.  The top-left corner maps to
        // c = -2.5 - 1.15i, which escapes right after the first iteration.
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd0, 1'b1, 8'd0, 16'd1},
        // c = -1 lies inside the set and runs to the limit.
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd320, 12'd240, 1'b0, 8'd0, 16'd0},
        // Far outside the frame: both parts of c saturate, one iteration.
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd4095, 12'd4095, 1'b1, 8'd0, 16'd1},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd639, 12'd479, 1'b0, 8'd0, 16'd0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd480, 12'd120, 1'b0, 8'd0, 16'd0},
        // A limit of one: every pixel stops after one iteration at full green.
        '{1'b1, 16'd640, 16'd480, 16'd1, 12'd320, 12'd240, 1'b1, 8'd172, 16'd1},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd4095, 12'd0, 1'b1, 8'd172, 16'd1},
        // A zero limit runs no iteration at all.
        '{1'b1, 16'd640, 16'd480, 16'd0, 12'd320, 12'd240, 1'b1, 8'd0, 16'd0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd4095, 1'b1, 8'd0, 16'd0},
        // A 6 x 2 frame puts pixel (5, 1) exactly on c = 0, which never escapes:
        // the full 65535 iterations run.
        '{1'b1, 16'd6, 16'd2, 16'd65535, 12'd5, 12'd1, 1'b1, 8'd172, 16'd65535},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd0, 1'b1, 8'd0, 16'd1},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd6, 12'd0, 1'b0, 8'd0, 16'd0},
        // Zero width and height count as one.
        '{1'b1, 16'd0, 16'd0, 16'd300, 12'd0, 12'd0, 1'b0, 8'd0, 16'd0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd1, 12'd1, 1'b0, 8'd0, 16'd0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd4095, 12'd4095, 1'b0, 8'd0, 16'd0},
        // Width write with the upper data bits set: 8191 counts as the maximum size.
        '{1'b1, 16'hffff, 16'd4096, 16'd1000, 12'd2048, 12'd2048, 1'b0, 8'd0, 16'd0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd4095, 12'd4095, 1'b0, 8'd0, 16'd0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd1365, 12'd1000, 1'b0, 8'd0, 16'd0},
        // Height above the maximum size, limit two: the corner gives half green.
        '{1'b1, 16'd4096, 16'h3fff, 16'd2, 12'd0, 12'd0, 1'b1, 8'd86, 16'd1},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd4095, 12'd4095, 1'b0, 8'd0, 16'd0},
        // One-pixel frame at the largest limit; these points escape quickly.
        '{1'b1, 16'd1, 16'd1, 16'd65535, 12'd1, 12'd0, 1'b0, 8'd0, 16'd0},
        '{1'b0, 16'd0, 16'd0, 16'd0, 12'd0, 12'd1, 1'b0, 8'd0, 16'd0},
        '{1'b1, 16'd640, 16'd480, 16'd256, 12'd410, 12'd200, 1'b0, 8'd0, 16'd0}
    };

    logic                                clk;
    logic                                rst_n    = 1'b0;
    logic                                start    = 1'b0;
    logic [mep_pkg::COORD_W-1:0]         column   = '0;
    logic [mep_pkg::COORD_W-1:0]         row      = '0;
    logic                                busy;
    logic                                done;
    logic [mep_pkg::INT_W-1:0]           intensity;
    logic [mep_pkg::LIMIT_W-1:0]         iterations;
    logic                                cfg_we   = 1'b0;
    logic [mep_pkg::CFG_ADDR_W-1:0]      cfg_addr = '0;
    logic [mep_pkg::CFG_W-1:0]           cfg_data = '0;

    // Shadow copy of the core's registers, updated as the writes go out.
    logic [mep_pkg::DIM_REG_W-1:0]       width_reg  = mep_pkg::WIDTH_RESET;
    logic [mep_pkg::DIM_REG_W-1:0]       height_reg = mep_pkg::HEIGHT_RESET;
    logic [mep_pkg::LIMIT_W-1:0]         limit_reg  = mep_pkg::LIMIT_RESET;

    // Results still owed by the core, oldest first, and the bookkeeping of the run.
    pixel_result_t                       pending_results [$];
    pixel_result_t                       oldest;
    int                                  fail_count  = 0;
    longint                              cycle_count = 0;

    mandelbrot_escape_pixel_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .column     (column),
        .row        (row),
        .busy       (busy),
        .done       (done),
        .intensity  (intensity),
        .iterations (iterations),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Pixel predictor
    // ------------------------------------------------------------------

    // Frame size as the core uses it: zero counts as one, oversize as the maximum.
    function automatic longint unsigned eff_dim(input logic [mep_pkg::DIM_REG_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > mep_pkg::MAX_DIM)
        begin
            return mep_pkg::MAX_DIM;
        end
        return 64'(v);
    endfunction

    // Quotient n / d floored to FB fraction bits.  The integer part is capped at 16
    // before the fraction bits are shifted in, while the remainder keeps running.
    function automatic longint unsigned frac_quot(input longint unsigned n,
                                                  input longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        int              k;
        q   = n / d;
        rem = n % d;
        if (q > 16)
        begin
            q = 16;
        end
        for (k = 0; k < FB; k++)
        begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= d)
            begin
                rem = rem - d;
                q   = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic longint clip_q(input longint v);
        if (v > Q_HI)
        begin
            return Q_HI;
        end
        if (v < Q_LO)
        begin
            return Q_LO;
        end
        return v;
    endfunction

    // Q4 product with the magnitude truncated, so it rounds toward zero.  Both
    // magnitudes are at most 2^31, so the full product fits in 64 bits.
    function automatic longint fixed_mul(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m  = (ma * mb) >> FB;
        return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
    endfunction

    // Escape count and green level of one pixel under the shadow registers.
    function automatic pixel_result_t escape_pixel(input logic [mep_pkg::COORD_W-1:0] x,
                                                   input logic [mep_pkg::COORD_W-1:0] y);
        longint unsigned w;
        longint unsigned h;
        longint          cr;
        longint          ci;
        longint          zr;
        longint          zi;
        longint          rsq;
        longint          isq;
        longint          zrzi;
        int unsigned     n;
        pixel_result_t   res;
        w  = eff_dim(width_reg);
        h  = eff_dim(height_reg);
        cr = clip_q($signed(frac_quot(64'(x) * 3, w)) - C_RE_OFFSET);
        ci = clip_q($signed(frac_quot(64'(y) * 23, 10 * h)) - $signed(frac_quot(23, 20)));
        zr = 0;
        zi = 0;
        n  = 0;
        while (n < limit_reg)
        begin
            rsq = fixed_mul(zr, zr);
            isq = fixed_mul(zi, zi);
            if (rsq + isq >= ESC_BOUND)
            begin
                break;
            end
            zrzi = fixed_mul(zr, zi);
            zi   = clip_q(2 * zrzi + ci);
            zr   = clip_q(rsq - isq + cr);
            n++;
        end
        res.iterations = n[mep_pkg::LIMIT_W-1:0];
        res.intensity  = (limit_reg == '0) ? '0 : 8'((172 * n) / limit_reg);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Stops offering items and waits until the core has returned every result.
    // Since each item gives exactly one result, the core is idle after that.
    // start is only high while an expected result is pending, so it is dropped
    // inside the wait.
    task automatic wait_all_results();
        while (pending_results.size() != 0)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Writes all three registers on consecutive edges, with the core idle.
    task automatic program_frame(input logic [mep_pkg::CFG_W-1:0] w,
                                 input logic [mep_pkg::CFG_W-1:0] h,
                                 input logic [mep_pkg::CFG_W-1:0] lim);
        wait_all_results();
        cfg_we   <= 1'b1;
        cfg_addr <= mep_pkg::REG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_addr <= mep_pkg::REG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_addr <= mep_pkg::REG_ITER_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we     <= 1'b0;
        width_reg  = w[mep_pkg::DIM_REG_W-1:0];
        height_reg = h[mep_pkg::DIM_REG_W-1:0];
        limit_reg  = lim;
    endtask

    // Offers one item, after a random number of idle cycles in which the payload
    // carries noise, and records its expected result once the core takes it.
    // start is left high on acceptance; the next call or wait decides its level.
    task automatic send_pixel(input logic [mep_pkg::COORD_W-1:0] x,
                              input logic [mep_pkg::COORD_W-1:0] y,
                              input int idle_pct,
                              input logic typed,
                              input pixel_result_t typed_res);
        while ($urandom_range(99) < idle_pct)
        begin
            start  <= 1'b0;
            column <= 12'($urandom);
            row    <= 12'($urandom);
            @(posedge clk);
        end
        start  <= 1'b1;
        column <= x;
        row    <= y;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_results.push_back(typed ? typed_res : escape_pixel(x, y));
    endtask

    // Random frame size: mostly modest, with the zero, one, maximum and oversize
    // cases and full 16-bit write data mixed in.
    function automatic logic [mep_pkg::CFG_W-1:0] random_dim();
        case ($urandom_range(19))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd4096;
            3:       return 16'($urandom);
            4:       return 16'($urandom_range(4097, 8191));
            default: return 16'($urandom_range(2, 1024));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every strobe is matched against the oldest expectation.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected: intensity %0d, iterations %0d",
                         $time, intensity, iterations);
                fail_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (intensity !== oldest.intensity)
                begin
                    $display("%0t: intensity mismatch: expected %0d, got %0d",
                             $time, oldest.intensity, intensity);
                    fail_count++;
                end
                if (iterations !== oldest.iterations)
                begin
                    $display("%0t: iterations mismatch: expected %0d, got %0d",
                             $time, oldest.iterations, iterations);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        pixel_result_t               typed_res;
        pixel_case_t                 tc;
        int                          idle_pct;
        int                          seg_len;
        int                          sent;
        logic [mep_pkg::CFG_W-1:0]   lim;
        logic [mep_pkg::COORD_W-1:0] x;
        logic [mep_pkg::COORD_W-1:0] y;

        // Reset is held low from time zero and released on a clock edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, with a light sender idle rate.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            tc = DIRECTED_CASES[i];
            if (tc.load)
            begin
                program_frame(tc.width_val, tc.height_val, tc.limit_val);
            end
            typed_res.intensity  = tc.exp_intensity;
            typed_res.iterations = tc.exp_iterations;
            send_pixel(tc.col, tc.rw, 26, tc.typed, typed_res);
        end

        // Random part in three phases: the sender idles about a quarter of the
        // time, then about three quarters, then never.  Each phase is cut into
        // segments that each run under a freshly programmed frame and limit.
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 26 : (phase == 1) ? 74 : 0;
            sent     = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                case ($urandom_range(19))
                    0:       lim = 16'd0;
                    1:       lim = 16'd1;
                    2:       lim = 16'd2;
                    3:       lim = 16'($urandom_range(200, 1024));
                    default: lim = 16'($urandom_range(3, 200));
                endcase
                program_frame(random_dim(), random_dim(), lim);
                seg_len = $urandom_range(20, 80);
                for (int k = 0; k < seg_len && sent < RANDOM_ITEMS / 3; k++)
                begin
                    // Now and then the sender holds off until the core is empty.
                    if ($urandom_range(99) < 3)
                    begin
                        wait_all_results();
                    end
                    // Most pixels lie inside the frame; the rest span the whole
                    // coordinate range and mostly saturate.
                    if ($urandom_range(99) < 88)
                    begin
                        x = 12'($urandom_range(0, 32'(eff_dim(width_reg)) - 1));
                        y = 12'($urandom_range(0, 32'(eff_dim(height_reg)) - 1));
                    end
                    else
                    begin
                        x = 12'($urandom);
                        y = 12'($urandom);
                    end
                    send_pixel(x, y, idle_pct, 1'b0, typed_res);
                    sent++;
                end
            end
        end

        // Let every result come back, then watch for stray strobes a while longer.
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
